[rtl/pmdq_pkg.sv]
// pmdq_pkg: shared constants for the priority message deque.
// Operation and status codes, default sizes. No dependencies.
package pmdq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_BITS_DEF  = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int OP_BITS     = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_TAKE_EQ    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_TAKE_GE    = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOMATCH = 2'd3;

endpackage

[rtl/pmdq_ram.sv]
// pmdq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmdq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/priority_message_deque_core.sv]
// priority_message_deque_core: bounded ordered deque with priority extract.
// Uses pmdq_pkg (codes, defaults) and pmdq_ram (entry storage).
//
// Channel   Direction  Handshake            Beat
// --------  ---------  -------------------  -------------------------------------
// command   in         start & !busy        operation, priority_req, payload
// result    out        done (one cycle)     status, taken_payload, taken_priority,
//                                           count
//
// Steps from an accepted command to the result beat (done high):
//   push, unused codes, and any rejected command: decode, then the result.
//   pop front / pop back: decode issues one RAM read, then S_POP gives the result.
//   take: decode, then the scan compares one entry per cycle from the
//   front, then the gap is closed by moving one entry per cycle.
// The single RAM read port and the one priority comparator set this pace.
// Reset (rst, synchronous) empties the deque; RAM contents are not cleared.
// busy is high from the cycle after acceptance until the result beat shows;
// it is low in the result cycle, so the next command can go at its end.
// The receiver cannot stall: each result beat is shown once, for one cycle.
module priority_message_deque_core #(
  parameter int DEPTH         = pmdq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS  = pmdq_pkg::PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = pmdq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pmdq_pkg::OP_BITS-1:0]      operation,
  input  logic [PRIORITY_BITS-1:0]          priority_req,
  input  logic [PAYLOAD_BITS-1:0]           payload,
  output logic                              done,
  output logic [pmdq_pkg::STATUS_BITS-1:0]  status,
  output logic [PAYLOAD_BITS-1:0]           taken_payload,
  output logic [PRIORITY_BITS-1:0]          taken_priority,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  // Widths: AW ram address, CW count (holds DEPTH), SW room for head + pos.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = PAYLOAD_BITS + PRIORITY_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_SHWR   = 3'd4;

  // Logical position -> physical RAM address on the circular buffer.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(pos);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]                        state, state_next;
  logic [pmdq_pkg::OP_BITS-1:0]      op_r;
  logic [PRIORITY_BITS-1:0]          prio_r;
  logic [PAYLOAD_BITS-1:0]           pay_r;
  logic [AW-1:0]                     head, head_next;
  logic [CW-1:0]                     cnt, cnt_next;
  logic [AW-1:0]                     idx, idx_next;
  logic [PAYLOAD_BITS-1:0]           tk_pay, tk_pay_next;
  logic [PRIORITY_BITS-1:0]          tk_pri, tk_pri_next;

  // RAM side.
  logic                              we;
  logic [CW-1:0]                     wr_pos, rd_pos;
  logic [EW-1:0]                     wdata, rdata;
  logic [AW-1:0]                     waddr, raddr;

  // Finish request toward the result register.
  logic                              finish;
  logic [pmdq_pkg::STATUS_BITS-1:0]  fin_status;
  logic [PAYLOAD_BITS-1:0]           fin_pay;
  logic [PRIORITY_BITS-1:0]          fin_pri;

  // Shared comparator and index arithmetic.
  logic [PRIORITY_BITS-1:0]          rd_pri;
  logic [PAYLOAD_BITS-1:0]           rd_pay;
  logic                              hit;
  logic [SW-1:0]                     idx_p1, idx_p2, cnt_w;

  assign rd_pri = rdata[PRIORITY_BITS-1:0];
  assign rd_pay = rdata[EW-1:PRIORITY_BITS];
  assign hit    = (op_r == pmdq_pkg::OP_TAKE_EQ) ? (rd_pri == prio_r) : (rd_pri >= prio_r);
  assign idx_p1 = SW'(idx) + SW'(1);
  assign idx_p2 = SW'(idx) + SW'(2);
  assign cnt_w  = SW'(cnt);

  assign busy  = (state != S_IDLE);
  assign waddr = phys(head_next, wr_pos);
  assign raddr = phys(head, rd_pos);

  always_comb begin
    state_next  = state;
    head_next   = head;
    cnt_next    = cnt;
    idx_next    = idx;
    tk_pay_next = tk_pay;
    tk_pri_next = tk_pri;
    we          = 1'b0;
    wr_pos      = '0;
    wdata       = {pay_r, prio_r};
    rd_pos      = '0;
    finish      = 1'b0;
    fin_status  = pmdq_pkg::ST_OK;
    fin_pay     = '0;
    fin_pri     = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_r)
          pmdq_pkg::OP_PUSH_FRONT, pmdq_pkg::OP_PUSH_BACK: begin
            finish = 1'b1;
            if (cnt == CW'(DEPTH)) begin
              fin_status = pmdq_pkg::ST_FULL;
            end else begin
              we       = 1'b1;
              cnt_next = cnt + CW'(1);
              if (op_r == pmdq_pkg::OP_PUSH_FRONT) begin
                // new front sits one slot before the old head
                head_next = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
              end else begin
                wr_pos = cnt;
              end
            end
          end
          pmdq_pkg::OP_POP_FRONT, pmdq_pkg::OP_POP_BACK: begin
            if (cnt == '0) begin
              finish     = 1'b1;
              fin_status = pmdq_pkg::ST_EMPTY;
            end else begin
              rd_pos     = (op_r == pmdq_pkg::OP_POP_FRONT) ? '0 : cnt - CW'(1);
              state_next = S_POP;
            end
          end
          pmdq_pkg::OP_TAKE_EQ, pmdq_pkg::OP_TAKE_GE: begin
            if (cnt == '0) begin
              finish     = 1'b1;
              fin_status = pmdq_pkg::ST_NOMATCH;
            end else begin
              idx_next   = '0;
              rd_pos     = '0;
              state_next = S_CMP;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_POP: begin
        finish   = 1'b1;
        fin_pay  = rd_pay;
        fin_pri  = rd_pri;
        cnt_next = cnt - CW'(1);
        if (op_r == pmdq_pkg::OP_POP_FRONT) begin
          head_next = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        end
      end
      S_CMP: begin
        // rdata holds the entry at idx
        if (hit) begin
          tk_pay_next = rd_pay;
          tk_pri_next = rd_pri;
          if (idx_p1 < cnt_w) begin
            rd_pos     = idx_p1[CW-1:0];
            state_next = S_SHWR;
          end else begin
            finish   = 1'b1;
            fin_pay  = rd_pay;
            fin_pri  = rd_pri;
            cnt_next = cnt - CW'(1);
          end
        end else if (idx_p1 < cnt_w) begin
          idx_next = idx_p1[AW-1:0];
          rd_pos   = idx_p1[CW-1:0];
        end else begin
          finish     = 1'b1;
          fin_status = pmdq_pkg::ST_NOMATCH;
        end
      end
      S_SHWR: begin
        // rdata holds entry idx+1; move it down to idx
        we       = 1'b1;
        wr_pos   = CW'(idx);
        wdata    = rdata;
        idx_next = idx_p1[AW-1:0];
        if (idx_p2 < cnt_w) begin
          rd_pos = idx_p2[CW-1:0];
        end else begin
          finish   = 1'b1;
          fin_pay  = tk_pay;
          fin_pri  = tk_pri;
          cnt_next = cnt - CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      cnt   <= '0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      done  <= finish;
      if (finish) begin
        count <= cnt_next;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= operation;
      prio_r <= priority_req;
      pay_r  <= payload;
    end
    idx    <= idx_next;
    tk_pay <= tk_pay_next;
    tk_pri <= tk_pri_next;
    if (finish) begin
      status         <= fin_status;
      taken_payload  <= fin_pay;
      taken_priority <= fin_pri;
    end
  end

  pmdq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef NO_ASSERTIONS
  // Occupancy never exceeds capacity.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("deque count above capacity");

  // A result beat only closes a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  // Full is reported only with a full deque, empty only with an empty one.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == pmdq_pkg::ST_FULL |-> count == CW'(DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status == pmdq_pkg::ST_EMPTY |-> count == '0)
    else $error("empty status with entries held");
`endif

endmodule

[test/pmdq_checker.sv]
// pmdq_checker: watches the command and result channels of the deque core,
// keeps its own copy of the deque contents and checks every result beat.
// Depends on pmdq_pkg for operation and status codes.
module pmdq_checker
  import pmdq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [OP_BITS-1:0]           operation,
  input  logic [PRIORITY_BITS-1:0]     priority_req,
  input  logic [PAYLOAD_BITS-1:0]      payload,
  input  logic                         done,
  input  logic [STATUS_BITS-1:0]       status,
  input  logic [PAYLOAD_BITS-1:0]      taken_payload,
  input  logic [PRIORITY_BITS-1:0]     taken_priority,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output int                           fail_count,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_BITS = $clog2(DEPTH+1);

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [PAYLOAD_BITS-1:0]  pay;
    logic [PRIORITY_BITS-1:0] pri;
    logic [CNT_BITS-1:0]      cnt;
  } deque_outcome_t;

  // shadow deque, position 0 is the front
  logic [PAYLOAD_BITS-1:0]  shadow_pay [DEPTH];
  logic [PRIORITY_BITS-1:0] shadow_pri [DEPTH];
  int                       shadow_n;

  deque_outcome_t outcomes_due [$];

  // close the gap left by the entry at pos
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < shadow_n; i++) begin
      shadow_pay[i] = shadow_pay[i+1];
      shadow_pri[i] = shadow_pri[i+1];
    end
    shadow_n--;
  endfunction

  function automatic deque_outcome_t apply_command(logic [OP_BITS-1:0] op,
                                                   logic [PRIORITY_BITS-1:0] pri,
                                                   logic [PAYLOAD_BITS-1:0] pay);
    deque_outcome_t r;
    int             i;
    int             pos;
    bit             hit;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_n >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          for (i = shadow_n; i > 0; i--) begin
            shadow_pay[i] = shadow_pay[i-1];
            shadow_pri[i] = shadow_pri[i-1];
          end
          shadow_pay[0] = pay;
          shadow_pri[0] = pri;
          shadow_n++;
        end else begin
          shadow_pay[shadow_n] = pay;
          shadow_pri[shadow_n] = pri;
          shadow_n++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = (op == OP_POP_FRONT) ? 0 : shadow_n - 1;
          r.pay = shadow_pay[pos];
          r.pri = shadow_pri[pos];
          drop_entry(pos);
        end
      end
      OP_TAKE_EQ, OP_TAKE_GE: begin
        r.status = ST_NOMATCH;
        for (i = 0; i < shadow_n; i++) begin
          hit = (op == OP_TAKE_EQ) ? (shadow_pri[i] == pri) : (shadow_pri[i] >= pri);
          if (hit) begin
            r.status = ST_OK;
            r.pay    = shadow_pay[i];
            r.pri    = shadow_pri[i];
            drop_entry(i);
            break;
          end
        end
      end
      default: ;  // unused codes leave the deque alone
    endcase
    r.cnt = CNT_BITS'(shadow_n);
    return r;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
    shadow_n    = 0;
  end

  // Sampled at the rising edge, before the core's own updates land.
  always @(posedge clk) begin
    deque_outcome_t want;
    if (rst) begin
      shadow_n = 0;
      outcomes_due.delete();
    end else begin
      // result of an earlier beat first; a new command can share the edge
      if (done) begin
        if (outcomes_due.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (taken_payload !== want.pay) begin
            $error("taken_payload: expected 0x%0h, actual 0x%0h", want.pay, taken_payload);
            fail_count++;
          end
          if (taken_priority !== want.pri) begin
            $error("taken_priority: expected %0d, actual %0d", want.pri, taken_priority);
            fail_count++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, actual %0d", want.cnt, count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        outcomes_due.push_back(apply_command(operation, priority_req, payload));
      end
    end
    outstanding = outcomes_due.size();
  end

endmodule

[test/testbench.sv]
// testbench: drives commands into priority_message_deque_core and gives the
// verdict. Uses pmdq_pkg codes and pmdq_checker for prediction and compare.
module testbench;
  import pmdq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int PAYLOAD_BITS  = PAYLOAD_BITS_DEF;
  localparam int PRIORITY_BITS = PRIORITY_BITS_DEF;
  localparam int CNT_BITS      = $clog2(DEPTH+1);

  // codes the core must ignore
  localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_BEATS = 1320;
  localparam int MAX_GAP      = 12;
  // worst case per beat: the longest idle gap + a full-depth take + slack,
  // taken several times over
  localparam int CYCLE_LIMIT  = 400_000;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [OP_BITS-1:0]           operation;
  logic [PRIORITY_BITS-1:0]     priority_req;
  logic [PAYLOAD_BITS-1:0]      payload;
  logic                         done;
  logic [STATUS_BITS-1:0]       status;
  logic [PAYLOAD_BITS-1:0]      taken_payload;
  logic [PRIORITY_BITS-1:0]     taken_priority;
  logic [CNT_BITS-1:0]          count;

  int fail_count;
  int outstanding;
  int cycles;
  bit no_idle;   // stretch of back-to-back commands

  priority_message_deque_core #(
    .DEPTH         (DEPTH),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .priority_req   (priority_req),
    .payload        (payload),
    .done           (done),
    .status         (status),
    .taken_payload  (taken_payload),
    .taken_priority (taken_priority),
    .count          (count)
  );

  pmdq_checker #(
    .DEPTH         (DEPTH),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .priority_req   (priority_req),
    .payload        (payload),
    .done           (done),
    .status         (status),
    .taken_payload  (taken_payload),
    .taken_priority (taken_priority),
    .count          (count),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One command beat. Called at a falling edge; returns at a falling edge.
  // start stays up across a zero gap so the next command is not dropped
  // and raised within one step.
  task automatic issue(logic [OP_BITS-1:0] op, logic [PRIORITY_BITS-1:0] pri,
                       logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    start        <= 1'b1;
    operation    <= op;
    priority_req <= pri;
    payload      <= pay;
    // accepted at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Skewed priority: small values make equal-matches likely, the top band
  // exercises the at-least compare near its limit.
  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5, 6: return PRIORITY_BITS'($urandom_range(0, 7));
      7:       return PRIORITY_BITS'($urandom_range(248, 255));
      default: return PRIORITY_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PAYLOAD_BITS'($urandom_range(0, 65535));
  endfunction

  // Operation mix follows a fill / drain / balanced mode so the deque keeps
  // swinging between empty and full instead of hovering in the middle.
  function automatic logic [OP_BITS-1:0] pick_op(int mode);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      0:       begin push_pct = 75; pop_pct = 10; end  // fill
      1:       begin push_pct = 20; pop_pct = 40; end  // drain
      default: begin push_pct = 45; pop_pct = 25; end  // balanced
    endcase
    if (roll < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (roll < push_pct + pop_pct)
      return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (roll < 97)
      return $urandom_range(0, 1) ? OP_TAKE_GE : OP_TAKE_EQ;
    return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
  endfunction

  initial begin
    int i;
    int mode;
    int mode_left;
    logic [OP_BITS-1:0] op;

    rst          = 1'b1;
    start        = 1'b0;
    operation    = OP_PUSH_FRONT;
    priority_req = '0;
    payload      = '0;
    no_idle      = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    // everything on an empty deque: both pops report empty, both takes miss,
    // spare codes do nothing
    issue(OP_POP_FRONT, '0, '0);
    issue(OP_POP_BACK,  '1, '1);
    issue(OP_TAKE_EQ,   '0, '0);
    issue(OP_TAKE_GE,   '0, '0);
    issue(OP_SPARE_6,   '1, '1);
    issue(OP_SPARE_7,   '0, '0);
    // field extremes, then fill to the top with priorities 1..127
    issue(OP_PUSH_FRONT, '1, '1);
    issue(OP_PUSH_BACK,  '0, '0);
    for (i = 2; i < DEPTH; i++)
      issue((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
            PRIORITY_BITS'($urandom_range(1, 127)), pick_payload());
    // full on both ends
    issue(OP_PUSH_FRONT, 8'd200, 16'h1234);
    issue(OP_PUSH_BACK,  8'd200, 16'h4321);
    // no entry carries 128: miss; then pull the two extreme entries out of
    // the middle of a full deque
    issue(OP_TAKE_EQ, 8'd128, '0);
    issue(OP_TAKE_GE, '1, '0);
    issue(OP_TAKE_EQ, '0, '0);
    issue(OP_POP_FRONT, '0, '0);
    issue(OP_POP_BACK,  '0, '0);

    // --- random part ---
    mode      = 0;
    mode_left = 0;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      // every hundred beats pick whether the sender idles at all
      if (i % 100 == 0)
        no_idle = ($urandom_range(0, 2) == 0);
      op = pick_op(mode);
      issue(op, pick_priority(), pick_payload());
    end

    if (start)
      start <= 1'b0;

    // drain: wait for every result, then let a worst-case take finish
    while (outstanding != 0) @(negedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[priority_message_deque_core.f]
rtl/pmdq_pkg.sv
rtl/pmdq_ram.sv
rtl/priority_message_deque_core.sv
test/pmdq_checker.sv
test/testbench.sv
